// ----- hdl/hmlp_pkg.sv -----
// Shared constants, types and codes for the linear-probe hash map.
package hmlp_pkg;

    localparam int CAPACITY   = 64;
    localparam int HALF_CAP   = CAPACITY / 2;
    localparam int KEY_BYTES  = 8;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(HALF_CAP + 1);
    localparam int KEY_W      = 64;
    localparam int LEN_W      = 4;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = 6;

    // FNV-1a 64 offset basis; the prime is 2^40 + 0x1b3
    localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;

    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd4;

    localparam logic KIND_SET = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] value;
    } slot_t;

endpackage

// ----- hdl/hmlp_hash.sv -----
// Iterative FNV-1a 64 hash unit: one key byte per cycle.
module hmlp_hash
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [hmlp_pkg::KEY_W-1:0]      key_bytes,
    input  logic [hmlp_pkg::LEN_W-1:0]      key_len,
    output logic                            done,
    output logic [63:0]                     hash
);

    logic                           busy_reg, busy_next;
    logic [hmlp_pkg::LEN_W-1:0]     left_reg, left_next;
    logic [hmlp_pkg::KEY_W-1:0]     shift_reg, shift_next;
    logic [63:0]                    h_reg, h_next;
    logic [63:0]                    mix;
    logic [63:0]                    prod;

    // h * (2^40 + 0x1b3) mod 2^64; 0x1b3 = 256 + 128 + 32 + 16 + 2 + 1
    assign mix  = h_reg ^ {56'd0, shift_reg[7:0]};
    assign prod = (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5)
                + (mix << 4) + (mix << 1) + mix;

    assign done = busy_reg && (left_reg == '0);
    assign hash = h_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        left_next  = left_reg;
        shift_next = shift_reg;
        h_next     = h_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            left_next  = key_len;
            shift_next = key_bytes;
            h_next     = hmlp_pkg::HASH_BASIS;
        end
        else if (busy_reg)
        begin
            if (left_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                h_next     = prod;
                shift_next = shift_reg >> 8;
                left_next  = left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        h_reg     <= h_next;
    end

endmodule

// ----- hdl/hmlp_store.sv -----
// Slot memory: key, length and value per slot, one write and one registered read port.
module hmlp_store
(
    input  logic                            clk,
    input  logic                            we,
    input  logic [hmlp_pkg::IDX_W-1:0]      waddr,
    input  hmlp_pkg::slot_t                 wdata,
    input  logic [hmlp_pkg::IDX_W-1:0]      raddr,
    output hmlp_pkg::slot_t                 rdata
);

    hmlp_pkg::slot_t mem [hmlp_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/hash_map_linear_probe.sv -----
// Top level of the linear-probe hash map: request sequencer, slot flags and result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: kind; tdata: key_bytes, key_len, value
//  m_      | out | m_tvalid/m_tready  | tuser: status; tdata: value_out, entry_count
//
//  Each request hashes its key bytes, then probes P slots (1..64).
//  The hash unit takes one key byte per cycle; each probe is a memory read then a compare
//  on the single slot read port.
//  Reset clears the occupied flags (flip-flops) and the entry count at once; no sweep.
//  One request in flight; s_tready is high only while the sequencer is idle. A finished
//  result waits in the output register, and the next request is taken meanwhile.
module hash_map_linear_probe
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            s_tuser,        // [0] kind
    input  logic [103:0]    s_tdata,        // [63:0] key_bytes, [67:64] key_len,
                                            // [99:68] value, [103:100] zero
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [2:0]      m_tuser,        // [2:0] status
    output logic [39:0]     m_tdata         // [31:0] value_out, [37:32] entry_count,
                                            // [39:38] zero
);

    localparam int IDX_W   = hmlp_pkg::IDX_W;
    localparam int COUNT_W = hmlp_pkg::COUNT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [hmlp_pkg::CAPACITY-1:0]      slot_used_reg, slot_used_next;
    logic [COUNT_W-1:0]                 count_reg, count_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [IDX_W-1:0]                   probe_reg, probe_next;
    logic                               hit_reg, hit_next;
    logic                               empty_reg, empty_next;

    // request held for the whole walk
    logic                               kind_reg;
    logic [hmlp_pkg::KEY_W-1:0]         key_reg;
    logic [hmlp_pkg::LEN_W-1:0]         len_reg;
    logic [hmlp_pkg::VAL_W-1:0]         value_reg;

    logic                               m_tvalid_reg;
    logic [2:0]                         m_tuser_reg;
    logic [39:0]                        m_tdata_reg;

    logic                               in_accept;
    logic [hmlp_pkg::LEN_W-1:0]         len_c;
    logic [hmlp_pkg::KEY_W-1:0]         key_c;
    logic                               hash_done;
    logic [63:0]                        hash_val;
    hmlp_pkg::slot_t                    rd_slot;
    hmlp_pkg::slot_t                    wr_slot;
    logic                               mem_we;
    logic                               out_free;
    logic                               out_load;
    logic                               do_insert;
    logic [hmlp_pkg::STATUS_W-1:0]      res_status;
    logic [hmlp_pkg::VAL_W-1:0]         res_value;
    logic                               cur_used;
    logic                               key_match;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == S_DONE) && out_free;

    // clamp the length, zero the bytes past it
    always_comb
    begin
        len_c = s_tdata[67:64];
        if (len_c > hmlp_pkg::LEN_W'(hmlp_pkg::KEY_BYTES))
        begin
            len_c = hmlp_pkg::LEN_W'(hmlp_pkg::KEY_BYTES);
        end
        for (int b = 0; b < hmlp_pkg::KEY_BYTES; b++)
        begin
            key_c[8*b +: 8] = (hmlp_pkg::LEN_W'(b) < len_c) ? s_tdata[8*b +: 8] : 8'd0;
        end
    end

    hmlp_hash u_hash
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .key_bytes (key_c),
        .key_len   (len_c),
        .done      (hash_done),
        .hash      (hash_val)
    );

    assign wr_slot.key   = key_reg;
    assign wr_slot.len   = len_reg;
    assign wr_slot.value = value_reg;

    // read port follows the probe index; data for idx_reg is valid in S_CMP and S_DONE
    hmlp_store u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (wr_slot),
        .raddr (idx_reg),
        .rdata (rd_slot)
    );

    assign cur_used  = slot_used_reg[idx_reg];
    assign key_match = (rd_slot.len == len_reg) && (rd_slot.key == key_reg);

    // outcome of a finished walk
    always_comb
    begin
        res_status = hmlp_pkg::ST_REJECTED;
        res_value  = '0;
        do_insert  = 1'b0;
        mem_we     = 1'b0;
        if (kind_reg == hmlp_pkg::KIND_GET)
        begin
            if (hit_reg)
            begin
                res_status = hmlp_pkg::ST_FOUND;
                res_value  = rd_slot.value;
            end
            else
            begin
                res_status = hmlp_pkg::ST_NOT_FOUND;
            end
        end
        else if (value_reg == '0)
        begin
            res_status = hmlp_pkg::ST_REJECTED;
        end
        else if (hit_reg)
        begin
            res_status = hmlp_pkg::ST_UPDATED;
            mem_we     = out_load;
        end
        else if (empty_reg && (count_reg < COUNT_W'(hmlp_pkg::HALF_CAP)))
        begin
            res_status = hmlp_pkg::ST_INSERTED;
            do_insert  = 1'b1;
            mem_we     = out_load;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        probe_next     = probe_reg;
        hit_next       = hit_reg;
        empty_next     = empty_reg;
        slot_used_next = slot_used_reg;
        count_next     = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = hash_val[IDX_W-1:0];
                    probe_next = '0;
                    hit_next   = 1'b0;
                    empty_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!cur_used)
                begin
                    empty_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (key_match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (probe_reg == IDX_W'(hmlp_pkg::CAPACITY - 1))
                begin
                    // every slot visited, nothing usable
                    state_next = S_DONE;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;    // wraps at the table end
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (do_insert)
                    begin
                        slot_used_next[idx_reg] = 1'b1;
                        count_next              = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_used_reg <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            probe_reg     <= '0;
            hit_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_used_reg <= slot_used_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            hit_reg       <= hit_next;
            empty_reg     <= empty_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg  <= s_tuser;
            key_reg   <= key_c;
            len_reg   <= len_c;
            value_reg <= s_tdata[99:68];
        end
        if (out_load)
        begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= {2'b00, hmlp_pkg::ENTRY_W'(count_next), res_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // the count never passes the half-full limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(hmlp_pkg::HALF_CAP))
        else $error("entry count above limit");

    // the count moves only by an insert, and then by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && do_insert) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not bump count");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_load && do_insert) |=> $stable(count_reg))
        else $error("count changed without insert");

    // an insert lands on a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && do_insert) |-> !slot_used_reg[idx_reg])
        else $error("insert into occupied slot");

    // a hit always comes from an occupied slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && hit_reg) |-> slot_used_reg[idx_reg])
        else $error("hit on free slot");
`endif

endmodule

// ----- test/tb_hash_map_linear_probe.sv -----
// Self-checking testbench for the linear-probe hash map: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module tb_hash_map_linear_probe;

    localparam logic [63:0] HASH_MULT = 64'h0000_0100_0000_01b3;
    localparam int POOL_N          = 48;   // keys reused so sets update and gets hit
    localparam int EARLY_POOL      = 20;   // subset used before the table is filled
    localparam int RANDOM_PER_PASS = 130;
    localparam int RX_HOLD_CYCLES  = 400;  // long receiver hold-off; input must back up
    localparam int TAIL_CYCLES     = 300;  // worst request hashes eight bytes and probes all 64 slots

    typedef struct packed {
        logic [hmlp_pkg::STATUS_W-1:0] status;
        logic [hmlp_pkg::VAL_W-1:0]    value;
        logic [hmlp_pkg::ENTRY_W-1:0]  count;
    } result_t;

    // one directed request; known rows carry a hand-written result
    typedef struct packed {
        logic                          kind;
        logic [hmlp_pkg::KEY_W-1:0]    key;
        logic [hmlp_pkg::LEN_W-1:0]    len;
        logic [hmlp_pkg::VAL_W-1:0]    value;
        logic                          known;
        logic [hmlp_pkg::STATUS_W-1:0] status;
        logic [hmlp_pkg::VAL_W-1:0]    value_out;
        logic [hmlp_pkg::ENTRY_W-1:0]  count;
    } row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic           s_tuser = 1'b0;        // [0] kind
    logic [103:0]   s_tdata = '0;          // [63:0] key_bytes, [67:64] key_len,
                                           // [99:68] value, [103:100] zero
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [2:0]     m_tuser;               // [2:0] status
    logic [39:0]    m_tdata;               // [31:0] value_out, [37:32] entry_count,
                                           // [39:38] zero

    // shadow of the table, updated as each request is issued
    logic                        shadow_used [hmlp_pkg::CAPACITY];
    logic [hmlp_pkg::KEY_W-1:0]  shadow_key  [hmlp_pkg::CAPACITY];
    logic [hmlp_pkg::LEN_W-1:0]  shadow_len  [hmlp_pkg::CAPACITY];
    logic [hmlp_pkg::VAL_W-1:0]  shadow_val  [hmlp_pkg::CAPACITY];
    int                          shadow_count;

    result_t                     pending_results [$];
    result_t                     oldest;
    row_t                        directed_rows [$];
    logic [hmlp_pkg::KEY_W-1:0]  key_pool [POOL_N];
    logic [hmlp_pkg::LEN_W-1:0]  len_pool [POOL_N];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int errors = 0;

    hash_map_linear_probe i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // FNV-1a home slot, linear probe with wrap, then set/get on the shadow table
    function automatic result_t hash_map_apply(input logic kind,
                                               input logic [hmlp_pkg::KEY_W-1:0] key_in,
                                               input logic [hmlp_pkg::LEN_W-1:0] len_in,
                                               input logic [hmlp_pkg::VAL_W-1:0] val);
        result_t                    r;
        logic [hmlp_pkg::KEY_W-1:0] key;
        logic [63:0]                h;
        int                         len;
        int                         idx;
        bit                         hit;
        bit                         empty;
        len = (int'(len_in) > hmlp_pkg::KEY_BYTES) ? hmlp_pkg::KEY_BYTES : int'(len_in);
        key = key_in;
        if (len < 8)
            key = key & ((64'd1 << (8 * len)) - 64'd1);
        h = hmlp_pkg::HASH_BASIS;
        for (int i = 0; i < len; i++)
        begin
            h = h ^ ((key >> (8 * i)) & 64'hff);
            h = h * HASH_MULT;
        end
        idx = int'(h[hmlp_pkg::IDX_W-1:0]);
        hit = 1'b0;
        empty = 1'b0;
        for (int n = 0; n < hmlp_pkg::CAPACITY; n++)
        begin
            if (!shadow_used[idx])
            begin
                empty = 1'b1;
                break;
            end
            if (int'(shadow_len[idx]) == len && shadow_key[idx] == key)
            begin
                hit = 1'b1;
                break;
            end
            idx = (idx + 1) % hmlp_pkg::CAPACITY;
        end
        r.value = '0;
        if (kind == hmlp_pkg::KIND_GET)
        begin
            if (hit)
            begin
                r.status = hmlp_pkg::ST_FOUND;
                r.value  = shadow_val[idx];
            end
            else
                r.status = hmlp_pkg::ST_NOT_FOUND;
        end
        else if (val == '0)
            r.status = hmlp_pkg::ST_REJECTED;
        else if (hit)
        begin
            shadow_val[idx] = val;
            r.status = hmlp_pkg::ST_UPDATED;
        end
        else if (empty && shadow_count < hmlp_pkg::HALF_CAP)
        begin
            shadow_used[idx] = 1'b1;
            shadow_key[idx]  = key;
            shadow_len[idx]  = hmlp_pkg::LEN_W'(len);
            shadow_val[idx]  = val;
            shadow_count++;
            r.status = hmlp_pkg::ST_INSERTED;
        end
        else
            r.status = hmlp_pkg::ST_REJECTED;    // table full
        r.count = hmlp_pkg::ENTRY_W'(shadow_count);
        return r;
    endfunction

    // present one request and hold it until the handshake completes
    task automatic issue(input logic kind, input logic [hmlp_pkg::KEY_W-1:0] key,
                         input logic [hmlp_pkg::LEN_W-1:0] len,
                         input logic [hmlp_pkg::VAL_W-1:0] val);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, val, len, key};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic predict_and_issue(input logic kind, input logic [hmlp_pkg::KEY_W-1:0] key,
                                     input logic [hmlp_pkg::LEN_W-1:0] len,
                                     input logic [hmlp_pkg::VAL_W-1:0] val);
        pending_results.push_back(hash_map_apply(kind, key, len, val));
        issue(kind, key, len, val);
    endtask

    // mostly pool keys with junk above the length; some fully random keys
    task automatic random_request(input int pool_used);
        logic                       kind;
        logic [hmlp_pkg::KEY_W-1:0] key;
        logic [hmlp_pkg::KEY_W-1:0] mask;
        logic [hmlp_pkg::LEN_W-1:0] len;
        logic [hmlp_pkg::VAL_W-1:0] val;
        int                         p;
        kind = 1'($urandom_range(1, 0));
        if ($urandom_range(99, 0) < 85)
        begin
            p    = int'($urandom_range(pool_used - 1, 0));
            len  = len_pool[p];
            mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
            key  = (key_pool[p] & mask) | ({$urandom, $urandom} & ~mask);
        end
        else
        begin
            len = hmlp_pkg::LEN_W'($urandom_range(15, 0));
            key = {$urandom, $urandom};
        end
        val = ($urandom_range(99, 0) < 10) ? '0 : $urandom;
        predict_and_issue(kind, key, len, val);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    initial
    begin
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                m_tready <= 1'b0;
                for (int k = 0; k < RX_HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d value=%h count=%0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[37:32]);
                errors++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (m_tuser != oldest.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.status, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] != oldest.value)
                begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, oldest.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[37:32] != oldest.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, oldest.count, m_tdata[37:32]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("hash_map_linear_probe regression: fail");
        $finish;
    end

    initial
    begin
        row_t row;
        result_t predicted;
        for (int i = 0; i < hmlp_pkg::CAPACITY; i++)
        begin
            shadow_used[i] = 1'b0;
            shadow_key[i]  = '0;
            shadow_len[i]  = '0;
            shadow_val[i]  = '0;
        end
        shadow_count = 0;
        for (int i = 0; i < POOL_N; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            len_pool[i] = hmlp_pkg::LEN_W'($urandom_range(15, 0));
        end

        // kind, key, len, value, known, status, value_out, count
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'h61, 4'd1, 32'd0,
                                  1'b1, hmlp_pkg::ST_NOT_FOUND, 32'd0, 6'd0});
        // zero value on set
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'hffff_ffff_ffff_ffff, 4'd0, 32'd0,
                                  1'b1, hmlp_pkg::ST_REJECTED, 32'd0, 6'd0});
        // empty key; junk key bits are ignored
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'h1234, 4'd0, 32'd1,
                                  1'b1, hmlp_pkg::ST_INSERTED, 32'd0, 6'd1});
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'h0, 4'd0, 32'hffff_ffff,
                                  1'b1, hmlp_pkg::ST_FOUND, 32'd1, 6'd1});
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'hffff_ffff_ffff_ffff, 4'd8,
                                  32'hffff_ffff,
                                  1'b1, hmlp_pkg::ST_INSERTED, 32'd0, 6'd2});
        // length above eight acts as eight
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'hffff_ffff_ffff_ffff, 4'd15, 32'd0,
                                  1'b1, hmlp_pkg::ST_FOUND, 32'hffff_ffff, 6'd2});
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'hffff_ffff_ffff_ffff, 4'd7,
                                  32'h8000_0000,
                                  1'b1, hmlp_pkg::ST_INSERTED, 32'd0, 6'd3});
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'h00ff_ffff_ffff_ffff, 4'd7, 32'd0,
                                  1'b1, hmlp_pkg::ST_FOUND, 32'h8000_0000, 6'd3});
        // "ab" with junk past the length
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'hdead_beef_0000_6261, 4'd2, 32'd5,
                                  1'b1, hmlp_pkg::ST_INSERTED, 32'd0, 6'd4});
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'h0000_0000_0000_6261, 4'd2, 32'd0,
                                  1'b1, hmlp_pkg::ST_FOUND, 32'd5, 6'd4});
        // same bytes, length 10 -> eight bytes with zero characters inside
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'h0000_0000_0000_6261, 4'd10, 32'd9,
                                  1'b1, hmlp_pkg::ST_INSERTED, 32'd0, 6'd5});
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'h0000_0000_0000_6261, 4'd2, 32'd7,
                                  1'b1, hmlp_pkg::ST_UPDATED, 32'd0, 6'd5});
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'h1111_0000_0000_6261, 4'd2, 32'd0,
                                  1'b1, hmlp_pkg::ST_FOUND, 32'd7, 6'd5});
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'h0, 4'd3, 32'd3,
                                  1'b1, hmlp_pkg::ST_INSERTED, 32'd0, 6'd6});
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'h0, 4'd2, 32'd0,
                                  1'b1, hmlp_pkg::ST_NOT_FOUND, 32'd0, 6'd6});
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'hff00_0000, 4'd3, 32'd0,
                                  1'b1, hmlp_pkg::ST_FOUND, 32'd3, 6'd6});
        // zero value on an existing key changes nothing
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'h6261, 4'd2, 32'd0,
                                  1'b1, hmlp_pkg::ST_REJECTED, 32'd0, 6'd6});
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'h6261, 4'd2, 32'd0,
                                  1'b1, hmlp_pkg::ST_FOUND, 32'd7, 6'd6});
        directed_rows.push_back('{hmlp_pkg::KIND_SET, 64'h5555_5555_5555_5555, 4'd4,
                                  32'h5555_5555,
                                  1'b0, hmlp_pkg::ST_UPDATED, 32'd0, 6'd0});
        directed_rows.push_back('{hmlp_pkg::KIND_GET, 64'haaaa_aaaa_5555_5555, 4'd4,
                                  32'haaaa_aaaa,
                                  1'b0, hmlp_pkg::ST_UPDATED, 32'd0, 6'd0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first pass: sender idles lightly, receiver heavily
        tx_idle_pct = 20;
        rx_idle_pct = 77;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            predicted = hash_map_apply(row.kind, row.key, row.len, row.value);
            if (row.known)
                predicted = '{row.status, row.value_out, row.count};
            pending_results.push_back(predicted);
            issue(row.kind, row.key, row.len, row.value);
        end
        for (int i = 0; i < RANDOM_PER_PASS; i++)
            random_request(EARLY_POOL);
        wait_drained();

        // fill to half capacity while the receiver is held off, then hit the full limit
        hold_requests = 1;
        while (shadow_count < hmlp_pkg::HALF_CAP)
            predict_and_issue(hmlp_pkg::KIND_SET, {$urandom, $urandom}, 4'd8,
                              $urandom | 32'd1);
        repeat (3)
            predict_and_issue(hmlp_pkg::KIND_SET, {$urandom, $urandom}, 4'd8,
                              $urandom | 32'd1);

        // second pass: roles swapped
        tx_idle_pct = 77;
        rx_idle_pct = 20;
        for (int i = 0; i < RANDOM_PER_PASS; i++)
            random_request(POOL_N);

        // third pass: no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < RANDOM_PER_PASS; i++)
            random_request(POOL_N);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("hash_map_linear_probe regression: pass");
        else
            $display("hash_map_linear_probe regression: fail");
        $finish;
    end

endmodule
